@@ design/pcl_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcl_pkg
// Shared types and constants of the palette color lookup and blend core.
// ---------------------------------------------------------------------------
package pcl_pkg;

   localparam logic       REQ_WRITE   = 1'b0;
   localparam logic       REQ_LOOKUP  = 1'b1;

   localparam logic [1:0] BLEND_NONE   = 2'd0;
   localparam logic [1:0] BLEND_WRAP   = 2'd1;
   localparam logic [1:0] BLEND_NOWRAP = 2'd2;

   localparam logic [7:0] SCALE_NUM   = 8'hF0;
   localparam logic [7:0] FULL_BRIGHT = 8'hFF;

   localparam int PAL_DEPTH = 16;
   localparam int SLOT_W    = 4;
   localparam int RGB_W     = 24;
   localparam int CH_W      = 8;
   localparam int FRAC_W    = 4;

   typedef logic [RGB_W-1:0]  rgb_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CH_W-1:0]   chan_type;

   // One classified transaction as it travels from front to back.
   typedef struct packed {
      logic                is_lookup;
      slot_type            slot;
      rgb_type             rgb;
      logic [FRAC_W-1:0]   frac;
      logic                blend;
      logic [CH_W-1:0]     bright;
   } pcl_item_type;

endpackage

@@ design/palette_color_lookup_blend_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_color_lookup_blend_core
// 16-entry RGB palette with indexed lookup, linear blend and brightness.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_type, req_entry_slot,
//                                              req_entry_rgb, req_color_index,
//                                              req_blend_mode, req_brightness
//   rsp      out        rsp_valid/rsp_ready    rsp_pixel_rgb
//
// One transaction per cycle while no result is stalled; a lookup result
// passes through the queue, read, blend and brightness stages in turn.
// Write transactions update the palette and produce no result.
// The palette reads as zero after reset; reset is synchronous, active high.
// A stalled result holds the whole back pipeline; the front keeps taking
// transactions until the QUEUE_DEPTH entry queue fills.
// ---------------------------------------------------------------------------
module palette_color_lookup_blend_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [3:0]  req_entry_slot,
   input  logic [23:0] req_entry_rgb,
   input  logic [15:0] req_color_index,
   input  logic [1:0]  req_blend_mode,
   input  logic [7:0]  req_brightness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_pixel_rgb
);

   pcl_pkg::pcl_item_type front_item;
   pcl_pkg::pcl_item_type head_item;
   logic                  head_valid;
   logic                  q_pop;

   pcl_front u_front (
      .req_type    (req_type),
      .entry_slot  (req_entry_slot),
      .entry_rgb   (req_entry_rgb),
      .color_index (req_color_index),
      .blend_mode  (req_blend_mode),
      .brightness  (req_brightness),
      .item        (front_item)
   );

   pcl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_item  (front_item),
      .not_full   (req_ready),
      .pop        (q_pop),
      .head_item  (head_item),
      .head_valid (head_valid)
   );

   pcl_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_item     (head_item),
      .head_valid    (head_valid),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_rgb (rsp_pixel_rgb)
   );

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("outputs not idle after reset");

   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> head_valid)
      else $error("queue full but empty head");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> head_valid)
      else $error("pop from empty queue");

   a_stall_holds_queue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !q_pop)
      else $error("queue popped while result stalled");
`endif

endmodule

@@ design/pcl_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcl_front
// Classifies incoming transactions: applies no-wrap index compression,
// splits entry and fraction, and decides whether blending applies.
// ---------------------------------------------------------------------------
module pcl_front (
   input  logic                  req_type,
   input  logic [3:0]            entry_slot,
   input  logic [23:0]           entry_rgb,
   input  logic [15:0]           color_index,
   input  logic [1:0]            blend_mode,
   input  logic [7:0]            brightness,
   output pcl_pkg::pcl_item_type item
);

   logic [23:0] scaled_full;
   logic [7:0]  eff_index;

   assign scaled_full = color_index * pcl_pkg::SCALE_NUM;

   always_comb begin
      if (blend_mode == pcl_pkg::BLEND_NOWRAP) begin
         eff_index = scaled_full[15:8];
      end else begin
         eff_index = color_index[7:0];
      end
   end

   always_comb begin
      item.is_lookup = (req_type == pcl_pkg::REQ_LOOKUP);
      item.rgb       = entry_rgb;
      item.bright    = brightness;
      item.frac      = eff_index[3:0];
      item.blend     = (blend_mode != pcl_pkg::BLEND_NONE) && (eff_index[3:0] != 4'd0);
      if (req_type == pcl_pkg::REQ_LOOKUP) begin
         item.slot = eff_index[7:4];
      end else begin
         item.slot = entry_slot;
      end
   end

endmodule

@@ design/pcl_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcl_queue
// Small FIFO that decouples the front classifier from the back pipeline.
// ---------------------------------------------------------------------------
module pcl_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pcl_pkg::pcl_item_type push_item,
   output logic                  not_full,
   input  logic                  pop,
   output pcl_pkg::pcl_item_type head_item,
   output logic                  head_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   pcl_pkg::pcl_item_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign not_full   = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slots_ff[rd_ptr_ff];
   assign do_push    = push && not_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/pcl_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcl_back
// Palette memory plus a three-stage pipeline: entry read, blend,
// brightness scale into the result register.
// ---------------------------------------------------------------------------
module pcl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pcl_pkg::pcl_item_type head_item,
   input  logic                  head_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [23:0]           rsp_pixel_rgb
);

   // c0 + floor((c1 - c0) * frac / 16), same as the weighted sum >> 8
   function automatic pcl_pkg::chan_type blend_chan(
      input pcl_pkg::chan_type c0,
      input pcl_pkg::chan_type c1,
      input logic [3:0]        frac
   );
      logic signed [8:0]  diff;
      logic signed [13:0] prod;
      logic signed [9:0]  delta;
      logic signed [9:0]  sum;
      diff  = $signed({1'b0, c1}) - $signed({1'b0, c0});
      prod  = diff * $signed({1'b0, frac});
      delta = prod[13:4];
      sum   = $signed({2'b00, c0}) + delta;
      return sum[7:0];
   endfunction

   function automatic pcl_pkg::chan_type scale_chan(
      input pcl_pkg::chan_type c,
      input logic [7:0]        bright
   );
      logic [16:0] prod;
      prod = c * ({1'b0, bright} + 9'd1);
      return prod[15:8];
   endfunction

   pcl_pkg::rgb_type            pal_mem [pcl_pkg::PAL_DEPTH];
   logic [pcl_pkg::PAL_DEPTH-1:0] pal_vld_ff;

   logic                 advance;
   logic                 is_write;
   pcl_pkg::slot_type    next_slot;

   logic                 s1_valid_ff;
   pcl_pkg::rgb_type     s1_rd0_ff, s1_rd1_ff;
   logic                 s1_vld0_ff, s1_vld1_ff;
   logic [3:0]           s1_frac_ff;
   logic                 s1_blend_ff;
   logic [7:0]           s1_bright_ff;

   pcl_pkg::rgb_type     c0_rgb, c1_rgb, s2_rgb_in;

   logic                 s2_valid_ff;
   pcl_pkg::rgb_type     s2_rgb_ff;
   logic [7:0]           s2_bright_ff;

   pcl_pkg::rgb_type     out_rgb_in;
   logic                 out_valid_ff;
   pcl_pkg::rgb_type     out_rgb_ff;

   assign advance   = !out_valid_ff || rsp_ready;
   assign pop       = advance && head_valid;
   assign is_write  = !head_item.is_lookup;
   assign next_slot = head_item.slot + 1'b1;

   // palette memory
   always_ff @(posedge clock) begin
      if (pop && is_write) begin
         pal_mem[head_item.slot] <= head_item.rgb;
      end
      if (advance) begin
         s1_rd0_ff <= pal_mem[head_item.slot];
         s1_rd1_ff <= pal_mem[next_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
      end else if (pop && is_write) begin
         pal_vld_ff[head_item.slot] <= 1'b1;
      end
   end

   // stage 1: entry read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop && head_item.is_lookup;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_vld0_ff   <= pal_vld_ff[head_item.slot];
         s1_vld1_ff   <= pal_vld_ff[next_slot];
         s1_frac_ff   <= head_item.frac;
         s1_blend_ff  <= head_item.blend;
         s1_bright_ff <= head_item.bright;
      end
   end

   // stage 2: blend
   assign c0_rgb = s1_vld0_ff ? s1_rd0_ff : '0;
   assign c1_rgb = s1_vld1_ff ? s1_rd1_ff : '0;

   always_comb begin
      if (s1_blend_ff) begin
         s2_rgb_in = {blend_chan(c0_rgb[23:16], c1_rgb[23:16], s1_frac_ff),
                      blend_chan(c0_rgb[15:8],  c1_rgb[15:8],  s1_frac_ff),
                      blend_chan(c0_rgb[7:0],   c1_rgb[7:0],   s1_frac_ff)};
      end else begin
         s2_rgb_in = c0_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_rgb_ff    <= s2_rgb_in;
         s2_bright_ff <= s1_bright_ff;
      end
   end

   // stage 3: brightness into result register
   always_comb begin
      if (s2_bright_ff == pcl_pkg::FULL_BRIGHT) begin
         out_rgb_in = s2_rgb_ff;
      end else begin
         out_rgb_in = {scale_chan(s2_rgb_ff[23:16], s2_bright_ff),
                       scale_chan(s2_rgb_ff[15:8],  s2_bright_ff),
                       scale_chan(s2_rgb_ff[7:0],   s2_bright_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rgb_ff <= out_rgb_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_rgb = out_rgb_ff;

endmodule

@@ sim/tb_palette_color_lookup_blend_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_palette_color_lookup_blend_core
// Self-checking bench for the palette lookup, blend and brightness core.
// A shadow palette predicts every lookup result in acceptance order; writes
// update the shadow only. Directed cases cover the palette after reset,
// field extremes, every blend mode and wrap from entry 15 to 0; a long
// receiver hold-off fills the core; random traffic with random idles on
// both sides follows.
// ---------------------------------------------------------------------------
module tb_palette_color_lookup_blend_core;

   localparam logic [1:0] BLEND_MODE3  = 2'd3;
   localparam int         HOLD_CYCLES  = 200;
   localparam int         STALL_LIMIT  = 3000;
   localparam int         RANDOM_ITEMS = 1100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = pcl_pkg::REQ_WRITE;
   logic [3:0]  req_entry_slot = '0;
   logic [23:0] req_entry_rgb = '0;
   logic [15:0] req_color_index = '0;
   logic [1:0]  req_blend_mode = pcl_pkg::BLEND_NONE;
   logic [7:0]  req_brightness = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_pixel_rgb;

   pcl_pkg::rgb_type palette_shadow [pcl_pkg::PAL_DEPTH];
   pcl_pkg::rgb_type pixel_expected [$];
   int      error_count = 0;
   int      stall_cycles = 0;
   bit      quiet_mode = 1'b0;
   bit      hold_request = 1'b0;

   palette_color_lookup_blend_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_entry_slot  (req_entry_slot),
      .req_entry_rgb   (req_entry_rgb),
      .req_color_index (req_color_index),
      .req_blend_mode  (req_blend_mode),
      .req_brightness  (req_brightness),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_rgb   (rsp_pixel_rgb)
   );

   always #4 clock = ~clock;

   function automatic pcl_pkg::rgb_type predict_pixel(input logic [15:0] idx,
                                                      input logic [1:0] mode,
                                                      input logic [7:0] bright);
      logic [23:0]      scaled;
      logic [7:0]       pos;
      logic [3:0]       nxt_slot;
      pcl_pkg::rgb_type cur;
      pcl_pkg::rgb_type nxt;
      int               ch [3];
      int               w2;
      begin
         scaled   = 24'(idx) * 24'(pcl_pkg::SCALE_NUM);
         pos      = (mode == pcl_pkg::BLEND_NOWRAP) ? scaled[15:8] : idx[7:0];
         nxt_slot = pos[7:4] + 4'd1;
         cur      = palette_shadow[pos[7:4]];
         nxt      = palette_shadow[nxt_slot];
         w2       = int'(pos[3:0]) * 16;
         for (int i = 0; i < 3; i++) begin
            ch[i] = int'(cur[8*i +: 8]);
            if (pos[3:0] != 4'd0 && mode != pcl_pkg::BLEND_NONE)
               ch[i] = (ch[i] * (256 - w2) + int'(nxt[8*i +: 8]) * w2) >> 8;
            if (bright != pcl_pkg::FULL_BRIGHT)
               ch[i] = (ch[i] * (int'(bright) + 1)) >> 8;
         end
         return {ch[2][7:0], ch[1][7:0], ch[0][7:0]};
      end
   endfunction

   task automatic drive_request(input logic kind, input logic [3:0] slot,
                                input logic [23:0] rgb, input logic [15:0] idx,
                                input logic [1:0] mode, input logic [7:0] bright);
      int gap;
      begin
         gap = 0;
         if (!quiet_mode && $urandom_range(99) < 10)
            gap = $urandom_range(4, 1);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         @(negedge clock);
         req_valid       <= 1'b1;
         req_type        <= kind;
         req_entry_slot  <= slot;
         req_entry_rgb   <= rgb;
         req_color_index <= idx;
         req_blend_mode  <= mode;
         req_brightness  <= bright;
         do @(posedge clock); while (!req_ready);
         if (kind == pcl_pkg::REQ_WRITE)
            palette_shadow[slot] = rgb;
         else
            pixel_expected.push_back(predict_pixel(idx, mode, bright));
      end
   endtask

   task automatic write_entry(input logic [3:0] slot, input logic [23:0] rgb);
      drive_request(pcl_pkg::REQ_WRITE, slot, rgb, 16'($urandom), 2'($urandom),
                    8'($urandom));
   endtask

   task automatic lookup_pixel(input logic [15:0] idx, input logic [1:0] mode,
                               input logic [7:0] bright);
      drive_request(pcl_pkg::REQ_LOOKUP, 4'($urandom), 24'($urandom), idx, mode, bright);
   endtask

   // reads of a freshly reset palette must come back black
   task automatic test_reset_palette;
      lookup_pixel(16'h0000, pcl_pkg::BLEND_NONE, pcl_pkg::FULL_BRIGHT);
      lookup_pixel(16'hFFFF, pcl_pkg::BLEND_NOWRAP, 8'h00);
      lookup_pixel(16'h00F8, pcl_pkg::BLEND_WRAP, 8'h80);
   endtask

   task automatic test_directed;
      write_entry(4'd0, 24'hFFFFFF);
      write_entry(4'd15, 24'h80FF01);
      write_entry(4'd1, 24'h0F0F0F);
      write_entry(4'd8, 24'hA5C3E1);
      lookup_pixel(16'h0000, pcl_pkg::BLEND_NONE, pcl_pkg::FULL_BRIGHT);
      lookup_pixel(16'h00F0, pcl_pkg::BLEND_NONE, pcl_pkg::FULL_BRIGHT);
      lookup_pixel(16'h0008, pcl_pkg::BLEND_WRAP, pcl_pkg::FULL_BRIGHT);
      lookup_pixel(16'h00FF, pcl_pkg::BLEND_WRAP, pcl_pkg::FULL_BRIGHT);   // wraps 15 -> 0
      lookup_pixel(16'h0010, pcl_pkg::BLEND_WRAP, pcl_pkg::FULL_BRIGHT);   // zero fraction
      lookup_pixel(16'h00F8, BLEND_MODE3, pcl_pkg::FULL_BRIGHT);
      lookup_pixel(16'hFFFF, pcl_pkg::BLEND_NOWRAP, pcl_pkg::FULL_BRIGHT);
      lookup_pixel(16'h1234, pcl_pkg::BLEND_NOWRAP, 8'h7F);
      lookup_pixel(16'h0004, pcl_pkg::BLEND_NONE, 8'h00);
      lookup_pixel(16'h0088, pcl_pkg::BLEND_WRAP, 8'hFE);
      lookup_pixel(16'hFF0C, pcl_pkg::BLEND_WRAP, 8'h00);
      lookup_pixel(16'h0000, pcl_pkg::BLEND_NONE, 8'h00);
   endtask

   // receiver holds off while lookups keep coming, so the core backs up
   task automatic test_backpressure;
      quiet_mode   = 1'b1;
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++)
         lookup_pixel(16'($urandom), 2'($urandom), 8'($urandom));
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_traffic;
      logic [15:0] idx;
      logic [7:0]  bright;
      int          pick;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_mode = (n >= 400 && n < 650);
         if ($urandom_range(99) < 25) begin
            write_entry(4'($urandom), 24'($urandom));
         end else begin
            idx = 16'($urandom);
            if ($urandom_range(99) < 20)
               idx[3:0] = 4'd0;
            pick = $urandom_range(99);
            if (pick < 30)
               bright = pcl_pkg::FULL_BRIGHT;
            else if (pick < 40)
               bright = 8'h00;
            else
               bright = 8'($urandom);
            lookup_pixel(idx, 2'($urandom), bright);
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (!quiet_mode && $urandom_range(99) < 20) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_expected.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time,
                     rsp_pixel_rgb);
         end else if (pixel_expected[0] !== rsp_pixel_rgb) begin
            error_count++;
            $display("%0t: pixel_rgb mismatch, expected %h, actual %h", $time,
                     pixel_expected[0], rsp_pixel_rgb);
            void'(pixel_expected.pop_front());
         end else begin
            void'(pixel_expected.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < pcl_pkg::PAL_DEPTH; i++)
         palette_shadow[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_palette();
      test_directed();
      test_backpressure();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pixel_expected.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
